>>> sv/jcl_pkg.sv
// shared types, constants and codes of the joint command limiter
package jcl_pkg;

    // default position width, Q8.24
    localparam int POSITION_WIDTH_DEF = 32;

    // configuration port
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_POSITION_MIN      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POSITION_MAX      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ZONE_FRACTION     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FLOOR_FACTOR      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_LIMIT        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_CHANGE_LIMIT = 3'd5;

    // fixed field widths
    localparam int LIMIT_W = 32;
    localparam int FRAC_W  = 17;
    localparam int STEP_W  = 31;

    // Q1.16 one
    localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

    // zone is normalized below this bit before the divide
    localparam int NORM_BIT = 40;

    // quotient bits of the factor divide
    localparam int QUO_W = 17;
    localparam int DIV_CNT_W = 5;

    // configuration register set
    typedef struct packed {
        logic [LIMIT_W-1:0] position_min;
        logic [LIMIT_W-1:0] position_max;
        logic [FRAC_W-1:0]  zone_fraction;
        logic [FRAC_W-1:0]  floor_factor;
        logic [STEP_W-1:0]  step_limit;
        logic [STEP_W-1:0]  step_change_limit;
    } jcl_cfg_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ZONE,
        S_CLASS,
        S_NORM,
        S_MUL,
        S_DIV,
        S_FACTOR,
        S_SCALE,
        S_LIMIT,
        S_STEP,
        S_FINISH
    } jcl_state_t;

    // how the deceleration factor is found
    typedef enum logic [1:0] {
        FAC_ONE,
        FAC_FLOOR,
        FAC_DIV
    } jcl_fac_mode_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic zone;
        logic classify;
        logic norm;
        logic mul;
        logic div_step;
        logic factor;
        logic scale;
        logic limit;
        logic step;
        logic finish;
    } jcl_cmd_t;

    // datapath to controller
    typedef struct packed {
        jcl_fac_mode_t mode;
        logic          zone_big;
    } jcl_status_t;

endpackage

>>> sv/jcl_ctrl.sv
// controller state machine of the joint command limiter
module jcl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  jcl_pkg::jcl_status_t status,
    output jcl_pkg::jcl_cmd_t   cmd
);

    jcl_pkg::jcl_state_t state_reg, state_next;
    logic [jcl_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jcl_pkg::S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            jcl_pkg::S_IDLE:
                if (in_valid)
                    state_next = jcl_pkg::S_ZONE;
            jcl_pkg::S_ZONE:
                state_next = jcl_pkg::S_CLASS;
            jcl_pkg::S_CLASS:
                if (status.mode == jcl_pkg::FAC_DIV)
                    state_next = jcl_pkg::S_NORM;
                else
                    state_next = jcl_pkg::S_SCALE;
            jcl_pkg::S_NORM:
                if (!status.zone_big)
                    state_next = jcl_pkg::S_MUL;
            jcl_pkg::S_MUL:
            begin
                state_next = jcl_pkg::S_DIV;
                cnt_next   = '0;
            end
            jcl_pkg::S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == jcl_pkg::DIV_CNT_W'(jcl_pkg::QUO_W - 1))
                    state_next = jcl_pkg::S_FACTOR;
            end
            jcl_pkg::S_FACTOR:
                state_next = jcl_pkg::S_SCALE;
            jcl_pkg::S_SCALE:
                state_next = jcl_pkg::S_LIMIT;
            jcl_pkg::S_LIMIT:
                state_next = jcl_pkg::S_STEP;
            jcl_pkg::S_STEP:
                state_next = jcl_pkg::S_FINISH;
            jcl_pkg::S_FINISH:
                if (out_free)
                    state_next = jcl_pkg::S_IDLE;
            default:
                state_next = jcl_pkg::S_IDLE;
        endcase
    end

    // outputs and commands
    always_comb
    begin
        cmd            = '0;
        in_stall       = (state_reg != jcl_pkg::S_IDLE);
        out_valid      = out_valid_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            jcl_pkg::S_IDLE:   cmd.load     = in_valid;
            jcl_pkg::S_ZONE:   cmd.zone     = 1'b1;
            jcl_pkg::S_CLASS:  cmd.classify = 1'b1;
            jcl_pkg::S_NORM:   cmd.norm     = status.zone_big;
            jcl_pkg::S_MUL:    cmd.mul      = 1'b1;
            jcl_pkg::S_DIV:    cmd.div_step = 1'b1;
            jcl_pkg::S_FACTOR: cmd.factor   = 1'b1;
            jcl_pkg::S_SCALE:  cmd.scale    = 1'b1;
            jcl_pkg::S_LIMIT:  cmd.limit    = 1'b1;
            jcl_pkg::S_STEP:   cmd.step     = 1'b1;
            jcl_pkg::S_FINISH:
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                end
            default: ;
        endcase
    end

endmodule

>>> sv/jcl_dp.sv
// datapath of the joint command limiter: zone, factor divide, step limits
module jcl_dp #(
    parameter int POSITION_WIDTH = jcl_pkg::POSITION_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  jcl_pkg::jcl_cfg_t                cfg,
    input  jcl_pkg::jcl_cmd_t                cmd,
    output jcl_pkg::jcl_status_t             status,
    input  logic signed [POSITION_WIDTH-1:0] current_position,
    input  logic signed [POSITION_WIDTH-1:0] target_position,
    output logic signed [POSITION_WIDTH-1:0] safe_position
);

    localparam int W  = POSITION_WIDTH;
    localparam int NW = (W > jcl_pkg::NORM_BIT) ? jcl_pkg::NORM_BIT : W;
    localparam int ZW = (W > jcl_pkg::NORM_BIT) ? W : jcl_pkg::NORM_BIT + 1;
    localparam int DW = ((W > 32) ? W : 32) + 3;
    localparam int FW = jcl_pkg::FRAC_W;
    localparam int QW = jcl_pkg::QUO_W;
    localparam int SW = jcl_pkg::STEP_W;
    localparam int LW = jcl_pkg::LIMIT_W;

    localparam logic signed [DW-1:0] POS_HI = {{(DW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [DW-1:0] POS_LO = {{(DW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [DW-1:0] S32_HI = {{(DW-LW+1){1'b0}}, {(LW-1){1'b1}}};
    localparam logic signed [DW-1:0] S32_LO = {{(DW-LW+1){1'b1}}, {(LW-1){1'b0}}};

    logic [63:0] pmin_ext, pmax_ext;
    logic signed [W-1:0] pmin, pmax;
    logic [FW-1:0] zf, fl;

    logic signed [W-1:0] cur_reg, clamped_reg, clamped;
    logic [W-1:0]        zone_reg, dist_reg;
    logic signed [W:0]   d_reg;
    logic                rpos_reg;
    logic [FW-1:0]       factor_reg;
    logic [NW-1:0]       rem_reg;
    logic [QW-1:0]       low_reg, quo_reg;
    logic [SW-1:0]       max_step_reg;
    logic signed [DW-1:0] delta_reg;
    logic signed [LW-1:0] prev_reg;
    logic signed [W-1:0]  safe_reg;

    logic signed [W:0]   range, dmin, dmax, d;
    logic [W+FW-1:0]     zprod;
    logic [ZW-1:0]       zone_ext;
    logic [NW+FW-1:0]    nprod;
    logic [NW:0]         trial, zdiv;
    logic [2*SW+2:0]     mprod;
    logic signed [DW-1:0] delta, ms, dv, lim, delta2, sum, prev_ext;

    // limits seen at the position width
    assign pmin_ext = {32'b0, cfg.position_min};
    assign pmax_ext = {32'b0, cfg.position_max};
    assign pmin     = signed'(pmin_ext[W-1:0]);
    assign pmax     = signed'(pmax_ext[W-1:0]);
    assign zf = (cfg.zone_fraction > jcl_pkg::ONE_Q16) ? jcl_pkg::ONE_Q16 : cfg.zone_fraction;
    assign fl = (cfg.floor_factor > jcl_pkg::ONE_Q16) ? jcl_pkg::ONE_Q16 : cfg.floor_factor;

    // clamp of the target, raise to min then lower to max
    always_comb
    begin
        clamped = (target_position < pmin) ? pmin : target_position;
        if (clamped > pmax)
            clamped = pmax;
    end

    // range, zone and distance to the nearer limit
    assign range = (W+1)'(pmax) - (W+1)'(pmin);
    assign zprod = W'(range[W-1:0]) * zf;
    assign dmin  = (W+1)'(cur_reg) - (W+1)'(pmin);
    assign dmax  = (W+1)'(pmax) - (W+1)'(cur_reg);
    assign d     = (dmin < dmax) ? dmin : dmax;

    assign zone_ext = ZW'(zone_reg);

    // factor mode and zone normalization status
    always_comb
    begin
        status.zone_big = |zone_ext[ZW-1:jcl_pkg::NORM_BIT];
        priority if (!rpos_reg || zone_reg == '0)
            status.mode = jcl_pkg::FAC_ONE;
        else if (!d_reg[W] && d_reg[W-1:0] >= zone_reg)
            status.mode = jcl_pkg::FAC_ONE;
        else if (d_reg[W] || d_reg == '0)
            status.mode = jcl_pkg::FAC_FLOOR;
        else
            status.mode = jcl_pkg::FAC_DIV;
    end

    // divide datapath
    assign nprod = dist_reg[NW-1:0] * (jcl_pkg::ONE_Q16 - fl);
    assign trial = {rem_reg, low_reg[QW-1]};
    assign zdiv  = {1'b0, zone_reg[NW-1:0]};

    // step scaling
    assign mprod = (2*SW+3)'(cfg.step_limit * factor_reg);

    // step limit against the scaled maximum
    always_comb
    begin
        ms    = DW'(signed'({1'b0, max_step_reg}));
        delta = DW'(clamped_reg) - DW'(cur_reg);
        if (delta > ms)
            delta = ms;
        else if (delta < -ms)
            delta = -ms;
    end

    // step change limit
    always_comb
    begin
        prev_ext = DW'(prev_reg);
        lim      = DW'(signed'({1'b0, cfg.step_change_limit}));
        dv       = delta_reg - prev_ext;
        delta2   = delta_reg;
        if (dv > lim)
            delta2 = prev_ext + lim;
        else if (dv < -lim)
            delta2 = prev_ext - lim;
    end

    // output sum
    assign sum = DW'(cur_reg) + delta_reg;

    // stored step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_reg <= '0;
        else if (cmd.step && cfg.step_change_limit != '0)
        begin
            if (delta2 > S32_HI)
                prev_reg <= S32_HI[LW-1:0];
            else if (delta2 < S32_LO)
                prev_reg <= S32_LO[LW-1:0];
            else
                prev_reg <= delta2[LW-1:0];
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg     <= current_position;
            clamped_reg <= clamped;
        end
        if (cmd.zone)
        begin
            rpos_reg <= !range[W] && range != '0;
            zone_reg <= zprod[W+FW-2:FW-1];
            d_reg    <= d;
        end
        if (cmd.classify)
        begin
            factor_reg <= (status.mode == jcl_pkg::FAC_FLOOR) ? fl : jcl_pkg::ONE_Q16;
            dist_reg   <= d_reg[W-1:0];
        end
        if (cmd.norm)
        begin
            zone_reg <= zone_reg >> 1;
            dist_reg <= dist_reg >> 1;
        end
        if (cmd.mul)
        begin
            rem_reg <= nprod[NW+FW-1:QW];
            low_reg <= nprod[QW-1:0];
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            low_reg <= {low_reg[QW-2:0], 1'b0};
            if (trial >= zdiv)
            begin
                rem_reg <= NW'(trial - zdiv);
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[NW-1:0];
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
        end
        if (cmd.factor)
            factor_reg <= fl + quo_reg;
        if (cmd.scale)
            max_step_reg <= mprod[SW+15:16];
        if (cmd.limit)
            delta_reg <= delta;
        if (cmd.step && cfg.step_change_limit != '0)
            delta_reg <= delta2;
        if (cmd.finish)
        begin
            if (sum > POS_HI)
                safe_reg <= POS_HI[W-1:0];
            else if (sum < POS_LO)
                safe_reg <= POS_LO[W-1:0];
            else
                safe_reg <= sum[W-1:0];
        end
    end

    assign safe_position = safe_reg;

endmodule

>>> sv/joint_command_limiter.sv
// Joint command limiter top level: configuration registers, controller and datapath.
// One position command per transfer: the target is clamped to the hard limits, the
// step is limited to step_limit scaled down near either limit, then to a change of
// at most step_change_limit from the previous step when that limit is nonzero, and
// the sum is saturated. When the scale needs the divide, a zone at or above 2^40 is
// first halved, with the distance, until it lies below; the divide is a restoring
// unit giving one quotient bit per cycle, 17 bits in all. The next item is taken
// once the current one has reached the output register, which holds its result
// until the output side takes it. Configuration writes take effect at once.
module joint_command_limiter #(
    parameter int POSITION_WIDTH = jcl_pkg::POSITION_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [POSITION_WIDTH-1:0]    current_position,
    input  logic signed [POSITION_WIDTH-1:0]    target_position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [POSITION_WIDTH-1:0]    safe_position,
    input  logic                                cfg_write,
    input  logic [jcl_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [jcl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    jcl_pkg::jcl_cfg_t    cfg_reg;
    jcl_pkg::jcl_cmd_t    cmd;
    jcl_pkg::jcl_status_t status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.position_min      <= 32'h8000_0000;
            cfg_reg.position_max      <= 32'h7FFF_FFFF;
            cfg_reg.zone_fraction     <= '0;
            cfg_reg.floor_factor      <= jcl_pkg::ONE_Q16;
            cfg_reg.step_limit        <= 31'h7FFF_FFFF;
            cfg_reg.step_change_limit <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                jcl_pkg::REG_POSITION_MIN:
                    cfg_reg.position_min <= cfg_data;
                jcl_pkg::REG_POSITION_MAX:
                    cfg_reg.position_max <= cfg_data;
                jcl_pkg::REG_ZONE_FRACTION:
                    cfg_reg.zone_fraction <= cfg_data[jcl_pkg::FRAC_W-1:0];
                jcl_pkg::REG_FLOOR_FACTOR:
                    cfg_reg.floor_factor <= cfg_data[jcl_pkg::FRAC_W-1:0];
                jcl_pkg::REG_STEP_LIMIT:
                    cfg_reg.step_limit <= cfg_data[jcl_pkg::STEP_W-1:0];
                jcl_pkg::REG_STEP_CHANGE_LIMIT:
                    cfg_reg.step_change_limit <= cfg_data[jcl_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencing
    jcl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic
    jcl_dp #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .cmd              (cmd),
        .status           (status),
        .current_position (current_position),
        .target_position  (target_position),
        .safe_position    (safe_position)
    );

    // a transfer in starts work, so the input side is held next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while an item is in work");

    // a result leaves only through a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result dropped without transfer");

    // apart from the load, the datapath only works while the input side is held
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.zone || cmd.div_step || cmd.finish) |-> in_stall)
        else $error("datapath busy while idle");

endmodule
